// ----- rtl/bira_pkg.sv -----
// Shared types, constants and reset values of the beat interval rate averager.
package bira_pkg;

  localparam int unsigned RATE_SLOTS_DEFAULT = 8;

  // Width of the shared divider, sized for the per-minute dividend and a 16 bit interval
  localparam int unsigned DIV_W = 16;
  localparam logic [DIV_W-1:0] MINUTE_MS = 16'd60000;
  localparam logic [7:0] RATE_MAX = 8'd255;

  localparam int unsigned CFG_W     = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_MS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FASTEST_INTERVAL_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST_INTERVAL_MS = 2'd3;

  localparam logic [17:0] PRESENCE_THRESHOLD_RST  = 18'd50000;
  localparam logic [15:0] REFRACTORY_MS_RST       = 16'd500;
  localparam logic [15:0] FASTEST_INTERVAL_MS_RST = 16'd500;
  localparam logic [15:0] SLOWEST_INTERVAL_MS_RST = 16'd1500;

  typedef struct packed {
    logic [17:0] ir_level;
    logic        beat_seen;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic       beat_counted;
    logic       rate_stored;
    logic [7:0] beat_rate;
    logic       average_valid;
    logic [7:0] average_rate;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/bira_ram.sv -----
// Generic single-port-write, registered-read RAM.
module bira_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bira_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module bira_div (
  input  logic               clk,
  input  logic               rst,
  input  bira_pkg::div_req_t req,
  output bira_pkg::div_rsp_t rsp
);

  localparam int unsigned W  = bira_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem, quo[W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= CW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when it fits
        if (fits) begin
          rem <= W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[W-1:0];
        end
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- rtl/beat_interval_rate_averager.sv -----
// Top level: beat gating, rate ring and running average around one shared divider.
//
//   channel   direction  handshake                  payload
//   sample    in         sample_valid/sample_stall  bira_pkg::sample_t
//   result    out        result_valid/result_stall  bira_pkg::result_t
//   config    in         cfg_write                  cfg_index, cfg_data
//
// A sample that stores no rate passes through EVAL and FIN; one that stores a rate also passes
// through RATE_WAIT, UPDATE and AVG_WAIT, with two passes through the 16 step divider (rate, average).
// The ring average uses a running sum, so the cost does not grow with RATE_SLOTS.
// rst is synchronous: control state, config registers, last beat time, sum, count, average and ring position clear.
// A result waits in its own register; the next sample may be taken while it is stalled.
module beat_interval_rate_averager #(
  parameter int unsigned RATE_SLOTS = bira_pkg::RATE_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  bira_pkg::sample_t                  sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output bira_pkg::result_t                  result,
  input  logic                               cfg_write,
  input  logic [bira_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bira_pkg::CFG_W-1:0]         cfg_data
);

  localparam int unsigned POS_W = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(RATE_SLOTS + 1);
  localparam int unsigned SUM_W = $clog2(RATE_SLOTS * 255 + 1);
  localparam int unsigned DW    = bira_pkg::DIV_W;

  typedef enum logic [2:0] {
    IDLE, EVAL, RATE_WAIT, UPDATE, AVG_WAIT, FIN
  } state_t;

  state_t state;

  logic [17:0] presence_threshold;
  logic [15:0] refractory_ms;
  logic [15:0] fastest_interval_ms;
  logic [15:0] slowest_interval_ms;

  bira_pkg::sample_t smp;
  logic [31:0]       last_beat_time;
  logic [POS_W-1:0]  ring_position;
  logic [CNT_W-1:0]  filled_count;
  logic [SUM_W-1:0]  ring_sum;
  logic [7:0]        running_average;
  logic              counted;
  logic              stored;
  logic [7:0]        rate;

  bira_pkg::div_req_t div_req;
  bira_pkg::div_rsp_t div_rsp;
  logic [7:0]         old_rate;

  logic [31:0]      interval;
  logic             count_ok;
  logic             store_ok;
  logic             ring_full;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count_next;
  logic             result_free;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold  <= bira_pkg::PRESENCE_THRESHOLD_RST;
      refractory_ms       <= bira_pkg::REFRACTORY_MS_RST;
      fastest_interval_ms <= bira_pkg::FASTEST_INTERVAL_MS_RST;
      slowest_interval_ms <= bira_pkg::SLOWEST_INTERVAL_MS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bira_pkg::CFG_PRESENCE_THRESHOLD:  presence_threshold  <= cfg_data;
        bira_pkg::CFG_REFRACTORY_MS:       refractory_ms       <= cfg_data[15:0];
        bira_pkg::CFG_FASTEST_INTERVAL_MS: fastest_interval_ms <= cfg_data[15:0];
        bira_pkg::CFG_SLOWEST_INTERVAL_MS: slowest_interval_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign interval = smp.now_ms - last_beat_time;
  assign count_ok = smp.beat_seen && (smp.ir_level > presence_threshold) &&
                    !interval[31] && (interval >= {16'b0, refractory_ms});
  assign store_ok = (interval >= {16'b0, fastest_interval_ms}) &&
                    (interval <= {16'b0, slowest_interval_ms});

  assign ring_full  = (filled_count == CNT_W'(RATE_SLOTS));
  assign sum_wide   = {1'b0, ring_sum} + (SUM_W + 1)'(rate) -
                      (ring_full ? (SUM_W + 1)'(old_rate) : '0);
  assign sum_next   = sum_wide[SUM_W-1:0];
  assign count_next = ring_full ? filled_count : filled_count + CNT_W'(1);

  assign result_free  = !result_valid || !result_stall;
  assign sample_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      last_beat_time  <= '0;
      ring_position   <= '0;
      filled_count    <= '0;
      ring_sum        <= '0;
      running_average <= '0;
      div_req.start   <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (sample_valid) begin
            smp   <= sample;
            state <= EVAL;
          end
        end
        EVAL: begin
          counted <= count_ok;
          stored  <= count_ok && store_ok;
          rate    <= '0;
          if (count_ok) begin
            last_beat_time <= smp.now_ms;
          end
          if (count_ok && store_ok) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= bira_pkg::MINUTE_MS;
            div_req.divisor  <= interval[DW-1:0];
            state            <= RATE_WAIT;
          end else begin
            state <= FIN;
          end
        end
        RATE_WAIT: begin
          if (div_rsp.done) begin
            // saturate fast rates, a zero interval included
            rate  <= (div_rsp.quotient > DW'(bira_pkg::RATE_MAX)) ?
                     bira_pkg::RATE_MAX : div_rsp.quotient[7:0];
            state <= UPDATE;
          end
        end
        UPDATE: begin
          ring_sum      <= sum_next;
          filled_count  <= count_next;
          ring_position <= (ring_position == POS_W'(RATE_SLOTS - 1)) ?
                           '0 : ring_position + POS_W'(1);
          div_req.start    <= 1'b1;
          div_req.dividend <= DW'(sum_next);
          div_req.divisor  <= DW'(count_next);
          state            <= AVG_WAIT;
        end
        AVG_WAIT: begin
          if (div_rsp.done) begin
            running_average <= div_rsp.quotient[7:0];
            state           <= FIN;
          end
        end
        FIN: begin
          if (result_free) begin
            result_valid         <= 1'b1;
            result.beat_counted  <= counted;
            result.rate_stored   <= stored;
            result.beat_rate     <= rate;
            result.average_valid <= (filled_count != '0);
            result.average_rate  <= running_average;
            state                <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  bira_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // read the slot about to be overwritten during EVAL, write the new rate in UPDATE
  bira_ram #(
    .WIDTH (8),
    .DEPTH (RATE_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (state == UPDATE),
    .waddr (ring_position),
    .wdata (rate),
    .re    (state == EVAL),
    .raddr (ring_position),
    .rdata (old_rate)
  );

endmodule

// ----- rtl/bira_chk.sv -----
// Port-level checks of the beat interval rate averager, bound to the top level.
module bira_chk (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input bira_pkg::result_t result
);

  // a stalled result transfer holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // the block is busy in the cycle after it takes a sample
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous one still in work");

  a_stored_is_counted: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.rate_stored |-> result.beat_counted && result.average_valid)
    else $error("rate stored without a counted beat");

  a_rate_zero_unless_stored: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.rate_stored |-> result.beat_rate == 8'd0)
    else $error("beat rate nonzero with no rate stored");

endmodule

bind beat_interval_rate_averager bira_chk u_bira_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
